FILE: design/ced_pkg.sv
// Shared constants, types and codes of the edge detector core.
// No dependencies; every other design file imports this package.
package ced_pkg;

  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 128;
  localparam int LAG          = IMAGE_WIDTH + 1;
  localparam int FRAME        = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int TOTAL        = FRAME + 4 * LAG;

  localparam int P_W    = $clog2(TOTAL);
  localparam int X_W    = $clog2(IMAGE_WIDTH);
  localparam int Y_W    = $clog2(IMAGE_HEIGHT + 2);
  localparam int PIX_W  = 8;
  localparam int MAG_W  = 11;
  localparam int DIR_W  = 2;
  localparam int DATA_W = MAG_W + DIR_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } ced_op_t;

  typedef enum logic {
    CFG_HIGH = 1'b0,
    CFG_LOW  = 1'b1
  } ced_cfg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORZ = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_VERT = 2'd2,
    DIR_ANTI = 2'd3
  } ced_dir_t;

  typedef logic [DATA_W-1:0] ced_word_t;
  typedef ced_word_t [2:0][2:0] ced_win3_t;

  // One item travelling down the stage chain.
  typedef struct packed {
    logic             valid;
    logic [P_W-1:0]   pos;
    ced_word_t        data;
  } ced_tok_t;

  // Status of a stage window after an item has been shifted in.
  typedef struct packed {
    logic           valid;
    logic           ctr;
    logic           fin;
    logic [P_W-1:0] pos;
  } ced_win_t;

endpackage

FILE: design/ced_if.sv
// Handshake interfaces for the input, result and configuration channels.
// Depends on ced_pkg for field widths.
interface ced_in_if;
  import ced_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface

interface ced_out_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic last;
  modport source (output valid, output edge_res, output last, input ready);
  modport sink   (input valid, input edge_res, input last, output ready);
endinterface

interface ced_cfg_if;
  import ced_pkg::*;
  logic             valid;
  logic             ready;
  logic             index;
  logic [MAG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/canny_edge_detector_core.sv
// Top level of the streaming edge detector: blur, gradient, suppression, threshold.
// Depends on ced_pkg, the interfaces in ced_if.sv and ced_win3.
//
// The core takes one item per clock cycle while in_chan.ready is high: a pixel of a
// raster-order frame or a drain tick. Four 3x3 window stages are chained; each keeps its
// two previous lines in a synchronous memory that is read one column ahead, so a stage
// handles one item in every cycle. An item's result, if any, lands in a sixteen-entry
// result queue. The first result comes with the item that follows 4*(IMAGE_WIDTH+1) pixels;
// drain ticks then flush the rest, and each frame yields exactly IMAGE_WIDTH*IMAGE_HEIGHT
// results, the last one flagged with last. Drain ticks sent before the frame's last pixel
// are taken and dropped. in_chan.ready falls only while sixteen results are in flight or
// waiting, so with a sink that is always ready the rate is one item per cycle. Thresholds
// are to be written through cfg_chan only while the core is idle, which the core does not
// enforce; they need no setup sweep and the line memories need no clearing after reset.
module canny_edge_detector_core import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ced_in_if.sink     in_chan,
  ced_out_if.source  out_chan,
  ced_cfg_if.sink    cfg_chan
);

  logic [MAG_W-1:0]     high_r, low_r;
  logic [P_W-1:0]       p_r;
  logic [FIFO_AW:0]     pend_r, fifo_cnt_r;
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [1:0]           fifo_r [FIFO_DEPTH];
  ced_tok_t             tok0_r, tok1_r, tok2_r, tok3_r;
  ced_win3_t            w0, w1, w2, w3;
  ced_win_t             s0, s1, s2, s3;
  logic                 in_acc, take, out_acc, fifo_wr, res_item, edge_bit;

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= MAG_W'(100);
      low_r  <= MAG_W'(50);
    end else if (cfg_chan.valid) begin
      case (ced_cfg_idx_t'(cfg_chan.index))
        CFG_HIGH: high_r <= cfg_chan.data;
        CFG_LOW:  low_r  <= cfg_chan.data;
        default:  ;
      endcase
    end
  end

  // Input side: a drain tick inside the frame is taken and has no effect.
  assign in_chan.ready = (pend_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign take          = in_acc && !((p_r < P_W'(FRAME)) &&
                                     (ced_op_t'(in_chan.operation) == OP_DRAIN));
  assign res_item      = take && (p_r >= P_W'(4 * LAG));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r          <= '0;
      tok0_r.valid <= 1'b0;
    end else begin
      tok0_r.valid <= take;
      if (take) begin
        p_r <= (p_r == P_W'(TOTAL - 1)) ? '0 : p_r + 1'b1;
      end
    end
    tok0_r.pos  <= p_r;
    tok0_r.data <= DATA_W'(in_chan.pixel);
  end

  // Stage 0: 1-2-1 blur.
  ced_win3 u_blur (
    .clk(clk), .rst_n(rst_n), .tok(tok0_r), .start_pos(P_W'(0)), .win(w0), .st(s0)
  );

  logic [11:0] blur_sum;
  always_comb begin
    blur_sum = 12'(w0[0][0][7:0]) + {3'b0, w0[0][1][7:0], 1'b0} + 12'(w0[0][2][7:0])
             + {3'b0, w0[1][0][7:0], 1'b0} + {2'b0, w0[1][1][7:0], 2'b0}
             + {3'b0, w0[1][2][7:0], 1'b0}
             + 12'(w0[2][0][7:0]) + {3'b0, w0[2][1][7:0], 1'b0} + 12'(w0[2][2][7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tok1_r.valid <= 1'b0;
    else        tok1_r.valid <= s0.valid;
    tok1_r.pos  <= s0.pos;
    tok1_r.data <= DATA_W'(blur_sum[11:4]);
  end

  // Stage 1: Sobel gradients, L1 magnitude and direction.
  ced_win3 u_grad (
    .clk(clk), .rst_n(rst_n), .tok(tok1_r), .start_pos(P_W'(LAG)), .win(w1), .st(s1)
  );

  logic [9:0]        sx_p, sx_n, sy_p, sy_n, ax, ay;
  logic signed [10:0] gx, gy;
  ced_dir_t          dir;
  logic [MAG_W-1:0]  mag;
  always_comb begin
    sx_p = 10'(w1[0][2][7:0]) + {1'b0, w1[1][2][7:0], 1'b0} + 10'(w1[2][2][7:0]);
    sx_n = 10'(w1[0][0][7:0]) + {1'b0, w1[1][0][7:0], 1'b0} + 10'(w1[2][0][7:0]);
    sy_p = 10'(w1[0][0][7:0]) + {1'b0, w1[0][1][7:0], 1'b0} + 10'(w1[0][2][7:0]);
    sy_n = 10'(w1[2][0][7:0]) + {1'b0, w1[2][1][7:0], 1'b0} + 10'(w1[2][2][7:0]);
    gx   = $signed({1'b0, sx_p}) - $signed({1'b0, sx_n});
    gy   = $signed({1'b0, sy_p}) - $signed({1'b0, sy_n});
    ax   = gx[10] ? 10'(-gx) : gx[9:0];
    ay   = gy[10] ? 10'(-gy) : gy[9:0];
    mag  = {1'b0, ax} + {1'b0, ay};
    if ({1'b0, ax} >= {ay, 1'b0})
      dir = DIR_HORZ;
    else if ({1'b0, ay} >= {ax, 1'b0})
      dir = DIR_VERT;
    else if ((!gx[10] && gx != '0) == (!gy[10] && gy != '0))
      dir = DIR_DIAG;
    else
      dir = DIR_ANTI;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tok2_r.valid <= 1'b0;
    else        tok2_r.valid <= s1.valid;
    tok2_r.pos  <= s1.pos;
    tok2_r.data <= {dir, mag};
  end

  // Stage 2: non-maximum suppression along the stored direction.
  ced_win3 u_nms (
    .clk(clk), .rst_n(rst_n), .tok(tok2_r), .start_pos(P_W'(2 * LAG)), .win(w2), .st(s2)
  );

  logic [MAG_W-1:0] m, n1, n2, sup;
  always_comb begin
    m = w2[1][1][MAG_W-1:0];
    case (ced_dir_t'(w2[1][1][DATA_W-1:MAG_W]))
      DIR_HORZ: begin n1 = w2[1][0][MAG_W-1:0]; n2 = w2[1][2][MAG_W-1:0]; end
      DIR_DIAG: begin n1 = w2[0][0][MAG_W-1:0]; n2 = w2[2][2][MAG_W-1:0]; end
      DIR_VERT: begin n1 = w2[0][1][MAG_W-1:0]; n2 = w2[2][1][MAG_W-1:0]; end
      default:  begin n1 = w2[0][2][MAG_W-1:0]; n2 = w2[2][0][MAG_W-1:0]; end
    endcase
    sup = (m >= n1 && m >= n2) ? m : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tok3_r.valid <= 1'b0;
    else        tok3_r.valid <= s2.valid;
    tok3_r.pos  <= s2.pos;
    tok3_r.data <= DATA_W'(sup);
  end

  // Stage 3: double threshold with a strong neighbor anywhere in the 3x3 ring.
  ced_win3 u_thr (
    .clk(clk), .rst_n(rst_n), .tok(tok3_r), .start_pos(P_W'(3 * LAG)), .win(w3), .st(s3)
  );

  logic ring_hi;
  always_comb begin
    ring_hi = 1'b0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (!(r == 1 && c == 1) && (w3[r][c][MAG_W-1:0] > high_r))
          ring_hi = 1'b1;
    edge_bit = (w3[1][1][MAG_W-1:0] > high_r) ||
               ((w3[1][1][MAG_W-1:0] > low_r) && ring_hi);
  end

  // Result queue; pend_r counts results in the chain plus those waiting.
  assign fifo_wr        = s3.valid && s3.ctr;
  assign out_acc        = out_chan.valid && out_chan.ready;
  assign out_chan.valid = (fifo_cnt_r != '0);
  assign out_chan.edge_res = fifo_r[rd_ptr_r][1];
  assign out_chan.last     = fifo_r[rd_ptr_r][0];

  always_ff @(posedge clk) begin
    if (fifo_wr) fifo_r[wr_ptr_r] <= {edge_bit, s3.fin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      if (fifo_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW+1)'(fifo_wr) - (FIFO_AW+1)'(out_acc);
      pend_r     <= pend_r + (FIFO_AW+1)'(res_item) - (FIFO_AW+1)'(out_acc);
    end
  end

  // Checks.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr |-> (fifo_cnt_r != (FIFO_AW+1)'(FIFO_DEPTH)) || out_acc)
    else $error("result queue written while full");

  a_pend_covers: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r >= fifo_cnt_r)
    else $error("fewer results in flight than queued");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s3.valid && s3.fin) |-> (s3.pos == P_W'(TOTAL - 1)))
    else $error("frame end flagged at wrong position");

endmodule

FILE: design/ced_win3.sv
// One 3x3 stencil window over a two-line buffer memory with zero padding.
// Depends on ced_pkg.
module ced_win3 import ced_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ced_tok_t       tok,
  input  logic [P_W-1:0] start_pos,
  output ced_win3_t      win,
  output ced_win_t       st
);

  logic [2*DATA_W-1:0] line_mem [IMAGE_WIDTH];
  logic [2*DATA_W-1:0] rd_r;
  logic [X_W-1:0]      x_r, x_nxt, nx;
  logic [Y_W-1:0]      y_r, y_nxt;
  ced_word_t           col_r [3][3];
  ced_word_t           push [3];
  logic                lmask_r, rmask_r;
  ced_win_t            st_r;
  logic [P_W:0]        end_pos;
  logic                act, last_k, kge;

  assign end_pos = {1'b0, start_pos} + (P_W+1)'(FRAME + LAG);
  assign act     = tok.valid && (tok.pos >= start_pos) && ({1'b0, tok.pos} < end_pos);
  assign last_k  = ({1'b0, tok.pos} == end_pos - 1'b1);
  assign kge     = (y_r >= Y_W'(2)) || ((y_r == Y_W'(1)) && (x_r != '0));
  assign nx      = (x_r == X_W'(IMAGE_WIDTH - 1)) ? '0 : x_r + 1'b1;

  // Rows outside the frame read as zero.
  always_comb begin
    push[0] = (y_r >= Y_W'(2)) ? rd_r[2*DATA_W-1:DATA_W] : '0;
    push[1] = (y_r >= Y_W'(1) && y_r <= Y_W'(IMAGE_HEIGHT)) ? rd_r[DATA_W-1:0] : '0;
    push[2] = (y_r < Y_W'(IMAGE_HEIGHT)) ? tok.data : '0;
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (act) begin
      if (last_k) begin
        x_nxt = '0;
        y_nxt = '0;
      end else begin
        x_nxt = nx;
        y_nxt = (nx == '0) ? y_r + 1'b1 : y_r;
      end
    end
  end

  // The entry for the next column is read ahead, so it is ready when that item arrives.
  always_ff @(posedge clk) begin
    if (act) begin
      line_mem[x_r] <= {rd_r[DATA_W-1:0], tok.data};
      rd_r          <= line_mem[nx];
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      for (int r = 0; r < 3; r++) begin
        col_r[0][r] <= col_r[1][r];
        col_r[1][r] <= col_r[2][r];
        col_r[2][r] <= push[r];
      end
      lmask_r <= (x_r == X_W'(1));
      rmask_r <= (x_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r  <= '0;
      y_r  <= '0;
      st_r <= '0;
    end else begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      st_r.valid <= tok.valid;
      st_r.ctr   <= act && kge;
      st_r.fin   <= act && last_k;
      st_r.pos   <= tok.pos;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r][0] = lmask_r ? '0 : col_r[0][r];
      win[r][1] = col_r[1][r];
      win[r][2] = rmask_r ? '0 : col_r[2][r];
    end
  end

  assign st = st_r;

endmodule

FILE: dv/tb_canny_edge_detector_core.sv
// Self-checking testbench of canny_edge_detector_core: the first part of a frame.
// Depends on ced_pkg, the interfaces in ced_if.sv and the core itself.
`timescale 1ns / 1ps

module tb_canny_edge_detector_core;
  import ced_pkg::*;

  // Depth of each stage's sample history: two lines plus the 3x3 window.
  localparam int HIST = 2 * IMAGE_WIDTH + 3;
  // Indexes of the five sample histories kept by the predictor.
  localparam int ST_BLUR = 0;
  localparam int ST_GRAD = 1;
  localparam int ST_MAG  = 2;
  localparam int ST_DIR  = 3;
  localparam int ST_THR  = 4;
  localparam int CHUNK   = 300;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic edge_res;
    logic last;
  } edge_item_t;

  typedef struct {
    ced_op_t    op;
    logic [7:0] pix;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ced_in_if  in_chan ();
  ced_out_if out_chan ();
  ced_cfg_if cfg_chan ();

  canny_edge_detector_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #1 clk = ~clk;

  // Predictor state: thresholds, the stage histories and the frame position.
  logic [MAG_W-1:0] high_thr = 11'd100;
  logic [MAG_W-1:0] low_thr  = 11'd50;
  int unsigned      lines [5][HIST];
  int unsigned      frame_pos = 0;
  edge_item_t       edge_q[$];

  int unsigned items_sent = 0;
  int unsigned edges_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Sample of stage history s at raster index j offset by (dy, dx); zero outside the frame.
  function automatic int unsigned tap(int s, int unsigned j, int dy, int dx);
    int y;
    int x;
    y = int'(j / IMAGE_WIDTH) + dy;
    x = int'(j % IMAGE_WIDTH) + dx;
    if (y < 0 || y >= IMAGE_HEIGHT || x < 0 || x >= IMAGE_WIDTH) return 0;
    return lines[s][(y * IMAGE_WIDTH + x) % HIST];
  endfunction

  function automatic void store(int s, int unsigned k, int unsigned v);
    if (k < FRAME) lines[s][k % HIST] = v;
  endfunction

  // Advances the edge predictor by one accepted item and queues any result it causes.
  function automatic void predict_edge(ced_op_t op, logic [7:0] pix);
    int unsigned p;
    int unsigned j;
    int unsigned sum;
    int          gx;
    int          gy;
    int          ax;
    int          ay;
    int unsigned m;
    int unsigned n1;
    int unsigned n2;
    ced_dir_t    dir;
    bit          ring_hi;
    edge_item_t  res;
    p = frame_pos;
    // A drain tick before the frame's last pixel is dropped without effect.
    if (p < FRAME && op == OP_DRAIN) return;
    store(ST_BLUR, p, pix);
    if (p >= LAG && p - LAG < FRAME) begin
      j = p - LAG;
      sum = tap(ST_BLUR, j, -1, -1) + 2 * tap(ST_BLUR, j, -1, 0) + tap(ST_BLUR, j, -1, 1)
          + 2 * tap(ST_BLUR, j, 0, -1) + 4 * tap(ST_BLUR, j, 0, 0)
          + 2 * tap(ST_BLUR, j, 0, 1)
          + tap(ST_BLUR, j, 1, -1) + 2 * tap(ST_BLUR, j, 1, 0) + tap(ST_BLUR, j, 1, 1);
      store(ST_GRAD, j, (sum >> 4) & 8'hFF);
    end
    if (p >= 2 * LAG && p - 2 * LAG < FRAME) begin
      j = p - 2 * LAG;
      gx = int'(tap(ST_GRAD, j, -1, 1) + 2 * tap(ST_GRAD, j, 0, 1) + tap(ST_GRAD, j, 1, 1))
         - int'(tap(ST_GRAD, j, -1, -1) + 2 * tap(ST_GRAD, j, 0, -1)
                + tap(ST_GRAD, j, 1, -1));
      gy = int'(tap(ST_GRAD, j, -1, -1) + 2 * tap(ST_GRAD, j, -1, 0) + tap(ST_GRAD, j, -1, 1))
         - int'(tap(ST_GRAD, j, 1, -1) + 2 * tap(ST_GRAD, j, 1, 0)
                + tap(ST_GRAD, j, 1, 1));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      if (ax >= 2 * ay) dir = DIR_HORZ;
      else if (ay >= 2 * ax) dir = DIR_VERT;
      else if ((gx > 0) == (gy > 0)) dir = DIR_DIAG;
      else dir = DIR_ANTI;
      store(ST_MAG, j, (ax + ay) & 11'h7FF);
      store(ST_DIR, j, dir);
    end
    if (p >= 3 * LAG && p - 3 * LAG < FRAME) begin
      j = p - 3 * LAG;
      dir = ced_dir_t'(lines[ST_DIR][j % HIST][1:0]);
      m = tap(ST_MAG, j, 0, 0);
      case (dir)
        DIR_HORZ: begin n1 = tap(ST_MAG, j, 0, -1);  n2 = tap(ST_MAG, j, 0, 1);  end
        DIR_DIAG: begin n1 = tap(ST_MAG, j, -1, -1); n2 = tap(ST_MAG, j, 1, 1);  end
        DIR_VERT: begin n1 = tap(ST_MAG, j, -1, 0);  n2 = tap(ST_MAG, j, 1, 0);  end
        default: begin  n1 = tap(ST_MAG, j, -1, 1);  n2 = tap(ST_MAG, j, 1, -1); end
      endcase
      store(ST_THR, j, (m >= n1 && m >= n2) ? m : 0);
    end
    if (p >= 4 * LAG && p - 4 * LAG < FRAME) begin
      j = p - 4 * LAG;
      ring_hi = 1'b0;
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++)
          if (!(dy == 0 && dx == 0) && tap(ST_THR, j, dy, dx) > high_thr) ring_hi = 1'b1;
      m = tap(ST_THR, j, 0, 0);
      res.edge_res = (m > high_thr) || (m > low_thr && ring_hi);
      res.last = (j == FRAME - 1);
      edge_q.push_back(res);
    end
    p++;
    // After the drain of the last row the next item opens a new frame.
    if (p >= TOTAL) p = 0;
    frame_pos = p;
  endfunction

  // Offers one item at a falling edge, with random idle cycles ahead of it, and returns at
  // the falling edge after it is taken; valid stays high so the next item can follow at once.
  // Items numbered 1250 to 1499 go out with no idling, so the core runs at full rate.
  task automatic send_item(ced_op_t op, logic [7:0] pix);
    bit quiet;
    quiet = (items_sent >= 1250 && items_sent < 1500);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.pixel     <= pix;
    do @(posedge clk); while (!in_chan.ready);
    predict_edge(op, pix);
    items_sent++;
    @(negedge clk);
  endtask

  // Register writes are applied to the predictor at the edge that takes them.
  task automatic write_reg(ced_cfg_idx_t idx, logic [MAG_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    if (idx == CFG_HIGH) high_thr = val;
    else low_thr = val;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Stops offering, waits until every predicted edge result has arrived, then lets
  // in-flight drain ticks and pixels that have no result of their own clear the pipeline.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Pixel pattern with edges: checkerboard of extremes, noisy flats, plain noise or a checkerboard of 200 and 40.
  function automatic logic [7:0] pick_pixel(int mode);
    int unsigned x;
    int unsigned y;
    logic [7:0]  base;
    x = (frame_pos % IMAGE_WIDTH) / 8;
    y = (frame_pos / IMAGE_WIDTH) / 8;
    base = ((x + y) & 1) ? 8'd255 : 8'd0;
    case (mode)
      0: return base;
      1: return base ^ 8'($urandom_range(0, 15));
      2: return 8'($urandom_range(0, 255));
      default: return ((x * 37 + y * 11) & 1) ? 8'd200 : 8'd40;
    endcase
  endfunction

  // Random items: mostly pixels of a frame with a few early drain ticks mixed in; during
  // the drain phase, drain ticks and pixels that stand in for them.
  task automatic random_chunk(int unsigned count);
    int mode;
    mode = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 64 == 0) mode = $urandom_range(0, 3);
      if (frame_pos >= FRAME)
        send_item(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN, 8'($urandom));
      else if ($urandom_range(0, 99) < 3)
        send_item(OP_DRAIN, 8'($urandom));
      else
        send_item(OP_PIXEL, pick_pixel(mode));
    end
  endtask

  // Result side: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    edge_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      edges_seen++;
      if (edge_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: edge_res=%0b last=%0b",
                   out_chan.edge_res, out_chan.last);
      end else begin
        want = edge_q.pop_front();
        if (out_chan.edge_res !== want.edge_res || out_chan.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected edge_res=%0b last=%0b, got edge_res=%0b last=%0b",
                     edges_seen, want.edge_res, want.last, out_chan.edge_res, out_chan.last);
        end
      end
    end
  end

  // Result sink: random stalls, one long hold-off in the middle of a chunk that fills the
  // result queue and stalls the input, and a stretch with no stalls at all.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 950) begin
        hold_done = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (edges_seen >= 650 && edges_seen < 950) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_canny_edge_detector_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed rows: early drain ticks that must be dropped, mixed with the pixel extremes and
  // bit patterns that toggle every input bit.
  stim_row_t directed [20] = '{
    '{OP_DRAIN, 8'hFF}, '{OP_DRAIN, 8'h00}, '{OP_PIXEL, 8'h00}, '{OP_PIXEL, 8'hFF},
    '{OP_PIXEL, 8'hFF}, '{OP_PIXEL, 8'h00}, '{OP_PIXEL, 8'h55}, '{OP_PIXEL, 8'hAA},
    '{OP_DRAIN, 8'h55}, '{OP_PIXEL, 8'h01}, '{OP_PIXEL, 8'h80}, '{OP_PIXEL, 8'h7F},
    '{OP_PIXEL, 8'hFE}, '{OP_PIXEL, 8'hFF}, '{OP_PIXEL, 8'hFF}, '{OP_PIXEL, 8'h00},
    '{OP_PIXEL, 8'h00}, '{OP_PIXEL, 8'hFF}, '{OP_DRAIN, 8'hAA}, '{OP_PIXEL, 8'h0F}
  };

  // Threshold settings used between chunks, high then low; the extremes are among them.
  logic [MAG_W-1:0] thr_high [5] = '{11'd0,    11'd2047, 11'd2047, 11'd30, 11'd400};
  logic [MAG_W-1:0] thr_low  [5] = '{11'd0,    11'd2047, 11'd0,    11'd10, 11'd150};

  initial begin
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= OP_PIXEL;
    in_chan.pixel      <= '0;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.index     <= CFG_HIGH;
    cfg_chan.data      <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds are in force for the directed part and the first chunk.
    foreach (directed[i]) send_item(directed[i].op, directed[i].pix);
    random_chunk(CHUNK);
    // Further chunks, each under a new pair of thresholds.
    for (int k = 0; k < 5; k++) begin
      settle();
      write_reg(CFG_HIGH, (k == 4) ? 11'($urandom_range(50, 600)) : thr_high[k]);
      write_reg(CFG_LOW,  (k == 4) ? 11'($urandom_range(0, 200))  : thr_low[k]);
      random_chunk(CHUNK);
    end

    settle();
    if (mismatches == 0 && edge_q.size() == 0) begin
      $display("tb_canny_edge_detector_core: clean");
    end else begin
      $display("tb_canny_edge_detector_core: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ced_pkg.sv
design/ced_if.sv
design/ced_win3.sv
design/canny_edge_detector_core.sv
dv/tb_canny_edge_detector_core.sv
